// ----- hdl/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, codes and the blue-style colour table for the waveform
// segment summariser.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int SCALE_W     = 9;
    localparam int MAX_SCALE   = 256;
    localparam int HSUM_W      = 16;
    localparam int CSUM_W      = 11;
    localparam int DIVIDEND_W  = 19;
    localparam int DIVISOR_W   = 12;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [1:0] REG_STYLE = 2'd0;
    localparam logic [1:0] REG_BAND  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    // waveform styles
    localparam logic [1:0] STYLE_BLUE  = 2'd0;
    localparam logic [1:0] STYLE_RGB   = 2'd1;
    localparam logic [1:0] STYLE_THREE = 2'd2;

    // three-band layers
    localparam logic [1:0] BAND_LOW     = 2'd0;
    localparam logic [1:0] BAND_MID     = 2'd1;
    localparam logic [1:0] BAND_HIGH    = 2'd2;
    localparam logic [1:0] BAND_LOW_MID = 2'd3;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic       end_of_data;
    } frame_t;

    typedef struct packed {
        logic [7:0] height;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } segment_t;

    // blue-style colour, {red, green, blue}
    function automatic logic [23:0] blue_colour(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = {8'd0,   8'd104, 8'd144};
            3'd1:    c = {8'd0,   8'd136, 8'd176};
            3'd2:    c = {8'd0,   8'd168, 8'd232};
            3'd3:    c = {8'd0,   8'd184, 8'd216};
            3'd4:    c = {8'd120, 8'd184, 8'd216};
            3'd5:    c = {8'd136, 8'd192, 8'd232};
            3'd6:    c = {8'd136, 8'd192, 8'd232};
            default: c = {8'd200, 8'd224, 8'd232};
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/waveform_segment_summarizer_top.sv -----
// ----------------------------------------------------------------------------
// waveform_segment_summarizer_top
// Groups waveform frames into display segments and emits averaged height
// and colour per segment, using one shared restoring divider.
// ----------------------------------------------------------------------------
// Usage
//   frame channel: frame_valid / frame_stall / frame. A request is taken when
//   frame_valid is high and frame_stall low. frame_stall is high while a
//   frame is being worked on.
//   segment channel: segment_valid / segment_stall / segment. One request per
//   closed segment (scale frames, or earlier on end_of_data).
//   cfg_wr_en / cfg_index / cfg_data write style, band and scale; write only
//   while the block is idle.
// Sequence
//   a frame that does not close a segment passes through accept and
//   accumulate before the next frame can be taken.
//   a closing frame then runs n divisions on the shared divider, each
//   load, 19 quotient bits one per cycle, store; n = 2 in blue style,
//   4 in rgb style, 1 in three-band style; then the result is handed
//   over in the done state, which waits while the output register is
//   full and the receiver stalls.
// Reset clears configuration to style 0, band 0, scale 1 and empties the
// segment sums. A finished result sits in the output register; when the
// receiver stalls and a second result is ready, the block waits.
// ----------------------------------------------------------------------------
module waveform_segment_summarizer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    output logic                          frame_stall,
    input  wss_pkg::frame_t               frame,
    output logic                          segment_valid,
    input  logic                          segment_stall,
    output wss_pkg::segment_t             segment,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [wss_pkg::SCALE_W-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // division steps, in the order they run
    localparam logic [1:0] OP_HEIGHT = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_SECOND = 2'd2;
    localparam logic [1:0] OP_THIRD  = 2'd3;

    localparam int SW = wss_pkg::SCALE_W;
    localparam int HW = wss_pkg::HSUM_W;
    localparam int CW = wss_pkg::CSUM_W;
    localparam int NW = wss_pkg::DIVIDEND_W;
    localparam int DW = wss_pkg::DIVISOR_W;
    localparam int KW = wss_pkg::DIV_CNT_W;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          style_reg, style_next;
    logic [1:0]          band_reg, band_next;
    logic [SW-1:0]       scale_reg, scale_next;
    wss_pkg::frame_t     frame_reg, frame_next;
    logic [SW-1:0]       frames_reg, frames_next;
    logic [HW-1:0]       hsum_reg, hsum_next;
    logic [CW-1:0]       csum0_reg, csum0_next;
    logic [CW-1:0]       csum1_reg, csum1_next;
    logic [CW-1:0]       csum2_reg, csum2_next;
    logic [1:0]          op_reg, op_next;
    logic [NW-1:0]       quo_reg, quo_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       divisor_reg, divisor_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    logic [7:0]          res_h_reg, res_h_next;
    logic [7:0]          res0_reg, res0_next;
    logic [7:0]          res1_reg, res1_next;
    logic [7:0]          res2_reg, res2_next;
    logic                seg_valid_reg, seg_valid_next;
    wss_pkg::segment_t   seg_reg, seg_next;

    logic [SW-1:0]       sc;
    logic [SW-1:0]       frames_inc;
    logic [10:0]         lo_n;
    logic [9:0]          mid_n;
    logic [10:0]         hi_n;
    logic [18:0]         lo_prod;
    logic [17:0]         mid_prod;
    logic [21:0]         hi_prod;
    logic [7:0]          lo_v, mid_v, hi_v, band_v;
    logic [CW-1:0]       chan_sel;
    logic [NW-1:0]       chan_x255;
    logic [DW-1:0]       sc_x7;
    logic [DW:0]         rem_shift;
    logic                rem_ge;
    logic [1:0]          last_op;
    logic [23:0]         tab_colour;
    logic                seg_load;

    // effective scale, clamped to 1..MAX_SCALE
    always_comb
    begin
        if (scale_reg == '0)
        begin
            sc = SW'(1);
        end
        else if (scale_reg > SW'(wss_pkg::MAX_SCALE))
        begin
            sc = SW'(wss_pkg::MAX_SCALE);
        end
        else
        begin
            sc = scale_reg;
        end
    end

    // three-band terms, constant divides by reciprocal multiply
    assign lo_n     = {1'b0, frame_reg.byte_c, 2'b00} + 11'd5;
    assign mid_n    = {1'b0, frame_reg.byte_a, 1'b0} + {2'b00, frame_reg.byte_a} + 10'd5;
    assign hi_n     = {1'b0, frame_reg.byte_b, 2'b00} + {2'b00, frame_reg.byte_b, 1'b0}
                    + 11'd49;
    assign lo_prod  = 19'(lo_n) * 19'd205;
    assign mid_prod = 18'(mid_n) * 18'd205;
    assign hi_prod  = 22'(hi_n) * 22'd1311;
    assign lo_v     = lo_prod[18:11];
    assign mid_v    = {1'b0, mid_prod[17:11]};
    assign hi_v     = {3'b000, hi_prod[21:17]};

    always_comb
    begin
        case (band_reg)
            wss_pkg::BAND_LOW:  band_v = lo_v;
            wss_pkg::BAND_MID:  band_v = mid_v;
            wss_pkg::BAND_HIGH: band_v = hi_v;
            default:            band_v = lo_v + mid_v;
        endcase
    end

    always_comb
    begin
        case (style_reg)
            wss_pkg::STYLE_BLUE: last_op = OP_FIRST;
            wss_pkg::STYLE_RGB:  last_op = OP_THIRD;
            default:             last_op = OP_HEIGHT;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_FIRST:  chan_sel = csum0_reg;
            OP_SECOND: chan_sel = csum1_reg;
            default:   chan_sel = csum2_reg;
        endcase
    end

    assign frames_inc = frames_reg + SW'(1);
    assign chan_x255  = {chan_sel, 8'h00} - NW'(chan_sel);
    assign sc_x7      = {sc, 3'b000} - DW'(sc);
    assign rem_shift  = {rem_reg, quo_reg[NW-1]};
    assign rem_ge     = rem_shift >= {1'b0, divisor_reg};
    assign tab_colour = wss_pkg::blue_colour(res0_reg[2:0]);
    assign seg_load   = (state_reg == S_DONE) && (!seg_valid_reg || !segment_stall);

    always_comb
    begin
        state_next     = state_reg;
        style_next     = style_reg;
        band_next      = band_reg;
        scale_next     = scale_reg;
        frame_next     = frame_reg;
        frames_next    = frames_reg;
        hsum_next      = hsum_reg;
        csum0_next     = csum0_reg;
        csum1_next     = csum1_reg;
        csum2_next     = csum2_reg;
        op_next        = op_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        res_h_next     = res_h_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        res2_next      = res2_reg;
        seg_valid_next = seg_valid_reg;
        seg_next       = seg_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                wss_pkg::REG_STYLE: style_next = cfg_data[1:0];
                wss_pkg::REG_BAND:  band_next  = cfg_data[1:0];
                wss_pkg::REG_SCALE: scale_next = cfg_data;
                default:            ;
            endcase
        end

        if (seg_valid_reg && !segment_stall)
        begin
            seg_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_next = frame;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                case (style_reg)
                    wss_pkg::STYLE_BLUE:
                    begin
                        hsum_next  = hsum_reg + HW'(frame_reg.byte_a[4:0]);
                        csum0_next = csum0_reg + CW'(frame_reg.byte_a[7:5]);
                    end
                    wss_pkg::STYLE_RGB:
                    begin
                        hsum_next  = hsum_reg + HW'(frame_reg.byte_b[6:2]);
                        csum0_next = csum0_reg + CW'(frame_reg.byte_a[7:5]);
                        csum1_next = csum1_reg
                                   + CW'({frame_reg.byte_a[1:0], frame_reg.byte_b[7]});
                        csum2_next = csum2_reg + CW'(frame_reg.byte_a[4:2]);
                    end
                    default:
                    begin
                        hsum_next = hsum_reg + HW'(band_v);
                    end
                endcase
                frames_next = frames_inc;
                if (frames_inc >= sc || frame_reg.end_of_data)
                begin
                    op_next    = OP_HEIGHT;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (op_reg == OP_HEIGHT)
                begin
                    quo_next     = NW'(hsum_reg);
                    divisor_next = DW'(sc);
                end
                else if (style_reg == wss_pkg::STYLE_BLUE)
                begin
                    quo_next     = NW'(chan_sel);
                    divisor_next = DW'(sc);
                end
                else
                begin
                    quo_next     = chan_x255;
                    divisor_next = sc_x7;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_ge)
                begin
                    rem_next = DW'(rem_shift - {1'b0, divisor_reg});
                end
                else
                begin
                    rem_next = rem_shift[DW-1:0];
                end
                quo_next = {quo_reg[NW-2:0], rem_ge};
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == KW'(wss_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                case (op_reg)
                    OP_HEIGHT: res_h_next = quo_reg[7:0];
                    OP_FIRST:  res0_next  = quo_reg[7:0];
                    OP_SECOND: res1_next  = quo_reg[7:0];
                    default:   res2_next  = quo_reg[7:0];
                endcase
                if (op_reg == last_op)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op_next    = op_reg + 2'd1;
                    state_next = S_LOAD;
                end
            end
            S_DONE:
            begin
                if (seg_load)
                begin
                    seg_next.height = res_h_reg;
                    if (style_reg == wss_pkg::STYLE_BLUE)
                    begin
                        seg_next.red   = tab_colour[23:16];
                        seg_next.green = tab_colour[15:8];
                        seg_next.blue  = tab_colour[7:0];
                    end
                    else if (style_reg == wss_pkg::STYLE_RGB)
                    begin
                        seg_next.red   = res0_reg;
                        seg_next.green = res1_reg;
                        seg_next.blue  = res2_reg;
                    end
                    else
                    begin
                        seg_next.red   = '0;
                        seg_next.green = '0;
                        seg_next.blue  = '0;
                    end
                    seg_valid_next = 1'b1;
                    frames_next    = '0;
                    hsum_next      = '0;
                    csum0_next     = '0;
                    csum1_next     = '0;
                    csum2_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            style_reg     <= wss_pkg::STYLE_BLUE;
            band_reg      <= wss_pkg::BAND_LOW;
            scale_reg     <= SW'(1);
            frames_reg    <= '0;
            hsum_reg      <= '0;
            csum0_reg     <= '0;
            csum1_reg     <= '0;
            csum2_reg     <= '0;
            op_reg        <= OP_HEIGHT;
            cnt_reg       <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            style_reg     <= style_next;
            band_reg      <= band_next;
            scale_reg     <= scale_next;
            frames_reg    <= frames_next;
            hsum_reg      <= hsum_next;
            csum0_reg     <= csum0_next;
            csum1_reg     <= csum1_next;
            csum2_reg     <= csum2_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg   <= frame_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        res_h_reg   <= res_h_next;
        res0_reg    <= res0_next;
        res1_reg    <= res1_next;
        res2_reg    <= res2_next;
        seg_reg     <= seg_next;
    end

    assign frame_stall   = (state_reg != S_IDLE);
    assign segment_valid = seg_valid_reg;
    assign segment       = seg_reg;

    // a taken frame is always accumulated in the next cycle
    a_accept_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_stall) |=> (state_reg == S_ACC))
        else $error("accepted frame not accumulated");

    // frame count never runs past the largest segment
    a_frames_max: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= SW'(wss_pkg::MAX_SCALE))
        else $error("frame count beyond max scale");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < divisor_reg))
        else $error("divider remainder out of range");

    // handing over a result empties the segment and raises valid
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        seg_load |=> (frames_reg == '0 && hsum_reg == '0 && segment_valid))
        else $error("segment not cleared after result");

    // divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (divisor_reg != '0))
        else $error("zero divisor");

endmodule

// ----- test/waveform_segment_summarizer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_segment_summarizer_top_tb
// Self-checking bench for the segment summariser. Frames are driven from a
// queue of pending requests and predicted as they are taken. Segments are
// checked field by field in arrival order. Random idling runs on both
// channels, and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module waveform_segment_summarizer_top_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_SETS   = 16;
    localparam int SET_FRAMES    = 34;
    localparam int SW            = wss_pkg::SCALE_W;

    // style code with no name of its own, handled as three-band
    localparam logic [1:0] STYLE_SPARE = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 frame_valid   = 1'b0;
    logic                 frame_stall;
    wss_pkg::frame_t      frame         = '0;
    logic                 segment_valid;
    logic                 segment_stall = 1'b0;
    wss_pkg::segment_t    segment;
    logic                 cfg_wr_en     = 1'b0;
    logic [1:0]           cfg_index     = wss_pkg::REG_STYLE;
    logic [SW-1:0]        cfg_data      = '0;

    // blue-style colours, {red, green, blue}
    logic [23:0] ocean_shades [8] = '{
        {8'd0,   8'd104, 8'd144},
        {8'd0,   8'd136, 8'd176},
        {8'd0,   8'd168, 8'd232},
        {8'd0,   8'd184, 8'd216},
        {8'd120, 8'd184, 8'd216},
        {8'd136, 8'd192, 8'd232},
        {8'd136, 8'd192, 8'd232},
        {8'd200, 8'd224, 8'd232}
    };

    // configuration as the block should hold it
    logic [1:0]    cur_style = wss_pkg::STYLE_BLUE;
    logic [1:0]    cur_band  = wss_pkg::BAND_LOW;
    logic [SW-1:0] cur_scale = SW'(1);

    // open segment
    logic [8:0]  frames_held  = '0;
    logic [15:0] height_total = '0;
    logic [10:0] first_total  = '0;
    logic [10:0] second_total = '0;
    logic [10:0] third_total  = '0;

    wss_pkg::frame_t   pending_frames[$];
    wss_pkg::segment_t expected_segments[$];

    int   frames_queued      = 0;
    int   frames_accepted    = 0;
    int   error_count        = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic frame_taken        = 1'b0;
    logic receiver_held      = 1'b0;
    event hold_start;

    waveform_segment_summarizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame_stall   (frame_stall),
        .frame         (frame),
        .segment_valid (segment_valid),
        .segment_stall (segment_stall),
        .segment       (segment),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // accumulate one frame, push a segment when it closes
    function automatic void summarise_frame(input wss_pkg::frame_t f);
        int unsigned       eff;
        int unsigned       lo;
        int unsigned       mid;
        int unsigned       hi;
        int unsigned       divisor;
        logic [15:0]       word;
        logic [2:0]        shade;
        wss_pkg::segment_t seg;
        if (cur_scale == '0)
            eff = 1;
        else if (32'(cur_scale) > wss_pkg::MAX_SCALE)
            eff = wss_pkg::MAX_SCALE;
        else
            eff = 32'(cur_scale);
        word = {f.byte_a, f.byte_b};
        if (cur_style == wss_pkg::STYLE_BLUE)
        begin
            height_total += 16'(f.byte_a[4:0]);
            first_total  += 11'(f.byte_a[7:5]);
        end
        else if (cur_style == wss_pkg::STYLE_RGB)
        begin
            height_total += 16'(word[6:2]);
            first_total  += 11'(word[15:13]);
            second_total += 11'(word[9:7]);
            third_total  += 11'(word[12:10]);
        end
        else
        begin
            lo  = (4 * 32'(f.byte_c) + 5) / 10;
            mid = (3 * 32'(f.byte_a) + 5) / 10;
            hi  = (6 * 32'(f.byte_b) + 49) / 100;
            case (cur_band)
                wss_pkg::BAND_LOW:  height_total += 16'(lo);
                wss_pkg::BAND_MID:  height_total += 16'(mid);
                wss_pkg::BAND_HIGH: height_total += 16'(hi);
                default:            height_total += 16'(lo + mid);
            endcase
        end
        frames_held += 9'd1;
        if (32'(frames_held) < eff && !f.end_of_data)
            return;
        seg        = '0;
        seg.height = 8'(32'(height_total) / eff);
        if (cur_style == wss_pkg::STYLE_BLUE)
        begin
            shade = 3'(32'(first_total) / eff);
            {seg.red, seg.green, seg.blue} = ocean_shades[shade];
        end
        else if (cur_style == wss_pkg::STYLE_RGB)
        begin
            divisor   = eff * 7;
            seg.red   = 8'((32'(first_total) * 255) / divisor);
            seg.green = 8'((32'(second_total) * 255) / divisor);
            seg.blue  = 8'((32'(third_total) * 255) / divisor);
        end
        expected_segments.push_back(seg);
        frames_held  = '0;
        height_total = '0;
        first_total  = '0;
        second_total = '0;
        third_total  = '0;
    endfunction

    function automatic void push_frame(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic eod);
        wss_pkg::frame_t f;
        f.byte_a      = a;
        f.byte_b      = b;
        f.byte_c      = c;
        f.end_of_data = eod;
        pending_frames.push_back(f);
        frames_queued++;
    endfunction

    // extremes turn up more often than plain random would give
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [SW-1:0] pick_scale();
        int unsigned r;
        r = $urandom_range(11);
        if (r == 0)
            return '0;
        if (r == 1)
            return SW'($urandom_range(511, 257));
        if (r < 4)
            return SW'($urandom_range(24, 7));
        return SW'($urandom_range(6, 1));
    endfunction

    task automatic compare_field(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // wait for every request to be taken and every segment to arrive
    task automatic settle();
        while (frames_accepted != frames_queued || expected_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [SW-1:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            wss_pkg::REG_STYLE: cur_style = value[1:0];
            wss_pkg::REG_BAND:  cur_band  = value[1:0];
            wss_pkg::REG_SCALE: cur_scale = value;
            default:            ;
        endcase
    endtask

    // frame acceptance and prediction
    always @(posedge clk)
    begin
        frame_taken <= frame_valid && frame_stall === 1'b0;
        if (frame_valid && frame_stall === 1'b0)
        begin
            summarise_frame(frame);
            frames_accepted <= frames_accepted + 1;
        end
    end

    // frame driver
    always @(negedge clk)
    begin
        if (!frame_valid || frame_taken)
        begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                frame       <= pending_frames.pop_front();
                frame_valid <= 1'b1;
            end
            else
                frame_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
        segment_stall <= receiver_held || ($urandom_range(99) < receiver_stall_pct);

    always
    begin
        @(hold_start);
        receiver_held = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        receiver_held = 1'b0;
    end

    // segment monitor
    always @(posedge clk)
    begin
        wss_pkg::segment_t want;
        if (segment_valid === 1'b1 && segment_stall === 1'b0)
        begin
            if (expected_segments.size() == 0)
            begin
                error_count++;
                $display("%0t ns: segment with none expected, expected nothing, got %0d %0d %0d %0d",
                         $time, segment.height, segment.red, segment.green, segment.blue);
            end
            else
            begin
                want = expected_segments.pop_front();
                compare_field("height", want.height, segment.height);
                compare_field("red", want.red, segment.red);
                compare_field("green", want.green, segment.green);
                compare_field("blue", want.blue, segment.blue);
            end
        end
    end

    initial
    begin
        int k;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // blue style at the reset scale, one segment per frame
        push_frame(8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(8'hff, 8'hff, 8'hff, 1'b1);
        push_frame(8'h1f, 8'h00, 8'h00, 1'b0);
        push_frame(8'he0, 8'h00, 8'h00, 1'b0);
        push_frame(8'ha5, 8'h5a, 8'h3c, 1'b0);
        // zero scale behaves as one
        write_register(wss_pkg::REG_SCALE, 9'd0);
        push_frame(8'h60, 8'h00, 8'h00, 1'b0);
        // rgb, full segment then a short one closed by end of data
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_RGB));
        write_register(wss_pkg::REG_SCALE, 9'd2);
        push_frame(8'hff, 8'hff, 8'h00, 1'b0);
        push_frame(8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(8'h12, 8'h34, 8'h00, 1'b1);
        // three-band, oversized scale clamps, each band and its rounding
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_THREE));
        write_register(wss_pkg::REG_SCALE, 9'd511);
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_LOW));
        push_frame(8'h00, 8'h00, 8'hff, 1'b1);
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_MID));
        push_frame(8'd5, 8'h00, 8'h00, 1'b1);
        push_frame(8'hff, 8'h00, 8'h00, 1'b1);
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_HIGH));
        push_frame(8'h00, 8'd25, 8'h00, 1'b1);
        push_frame(8'h00, 8'hff, 8'h00, 1'b1);
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_LOW_MID));
        push_frame(8'hff, 8'h00, 8'hff, 1'b1);
        write_register(wss_pkg::REG_STYLE, SW'(STYLE_SPARE));
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_MID));
        push_frame(8'd5, 8'd75, 8'h00, 1'b1);
        // scale lowered under a part-filled segment
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_BLUE));
        write_register(wss_pkg::REG_SCALE, 9'd4);
        push_frame(8'hff, 8'h00, 8'h00, 1'b0);
        push_frame(8'hc3, 8'h00, 8'h00, 1'b0);
        push_frame(8'h81, 8'h00, 8'h00, 1'b0);
        write_register(wss_pkg::REG_SCALE, 9'd2);
        push_frame(8'hff, 8'h00, 8'h00, 1'b0);
        // style changed mid-segment keeps the partial sums
        write_register(wss_pkg::REG_SCALE, 9'd3);
        push_frame(8'h7f, 8'h00, 8'h00, 1'b0);
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_RGB));
        push_frame(8'hff, 8'hff, 8'h00, 1'b0);
        push_frame(8'ha5, 8'h5a, 8'h00, 1'b0);

        for (k = 0; k < RANDOM_SETS; k++)
        begin
            write_register(wss_pkg::REG_STYLE, SW'($urandom_range(3)));
            write_register(wss_pkg::REG_BAND, SW'($urandom_range(3)));
            write_register(wss_pkg::REG_SCALE, pick_scale());
            case (k / 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            // one segment per frame while the receiver holds off, so the block fills
            if (k == 9)
            begin
                write_register(wss_pkg::REG_SCALE, 9'd1);
                -> hold_start;
            end
            for (n = 0; n < SET_FRAMES; n++)
            begin
                // sender pauses until every segment is back
                if (k % 4 == 1 && n == SET_FRAMES / 2)
                    settle();
                push_frame(pick_byte(), pick_byte(), pick_byte(), $urandom_range(11) == 0);
            end
        end

        // largest scale, near full-range sums
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_THREE));
        write_register(wss_pkg::REG_BAND, SW'(wss_pkg::BAND_LOW_MID));
        push_frame(8'h00, 8'h00, 8'h00, 1'b1);
        write_register(wss_pkg::REG_SCALE, 9'd256);
        for (n = 0; n < wss_pkg::MAX_SCALE; n++)
        begin
            if ($urandom_range(7) == 0)
                push_frame(pick_byte(), pick_byte(), pick_byte(), 1'b0);
            else
                push_frame(8'hff, 8'hff, 8'hff, 1'b0);
        end
        // short rgb segment still divided by the full scale
        write_register(wss_pkg::REG_STYLE, SW'(wss_pkg::STYLE_RGB));
        for (n = 0; n < 40; n++)
            push_frame(8'hff, pick_byte(), pick_byte(), n == 39);

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
